// ===== hdl/efg_pkg.sv =====
package efg_pkg;
    localparam int FLAG_W  = 32;
    localparam int OP_W    = 3;
    localparam int HDL_W   = 5;
    localparam int MODE_W  = 3;
    localparam int WID_W   = 8;
    localparam int ST_W    = 3;
    localparam int SLOT_W  = 3;
    localparam int WAKE_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 3'd0, OP_CLOSE = 3'd1, OP_FREE = 3'd2,
        OP_POST = 3'd3, OP_WAIT = 3'd4, OP_STATUS = 3'd5
    } t_op;

    localparam logic [MODE_W-1:0] MODE_AND   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OR    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REPL  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_XOR   = 3'd3;
    localparam logic [MODE_W-1:0] WAIT_EVERY = 3'd0;
    localparam logic [MODE_W-1:0] WAIT_ANY   = 3'd1;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [ST_W-1:0] ST_NOGROUP = 3'd2;
    localparam logic [ST_W-1:0] ST_NOROOM  = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTOPEN = 3'd4;
    localparam logic [ST_W-1:0] ST_BADMODE = 3'd5;

    // classified command handed from front to back
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HDL_W-1:0]  handle;
        logic [FLAG_W-1:0] mask;
        logic [MODE_W-1:0] mode;
        logic [WID_W-1:0]  wid;
        logic [ST_W-1:0]   pre_st;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [HDL_W-1:0]  new_handle;
        logic [FLAG_W-1:0] flags_out;
        logic              satisfied;
        logic [SLOT_W-1:0] waiter_slot;
        logic [WAKE_W-1:0] wake_vector;
    } t_res;

    typedef enum logic [1:0] { S_IDLE, S_EXEC, S_OUT } t_state;
endpackage

// ===== hdl/efg_if.sv =====
interface efg_in_if;
    logic                      valid;
    logic                      ready;
    logic [efg_pkg::OP_W-1:0]   operation;
    logic [efg_pkg::HDL_W-1:0]  handle;
    logic [efg_pkg::FLAG_W-1:0] flag_mask;
    logic [efg_pkg::MODE_W-1:0] merge_mode;
    logic [efg_pkg::WID_W-1:0]  waiter_id;
    modport source (output valid, operation, handle, flag_mask, merge_mode, waiter_id,
                    input ready);
    modport sink (input valid, operation, handle, flag_mask, merge_mode, waiter_id,
                  output ready);
endinterface

interface efg_out_if;
    logic                      valid;
    logic                      ready;
    logic [efg_pkg::ST_W-1:0]   status;
    logic [efg_pkg::HDL_W-1:0]  new_handle;
    logic [efg_pkg::FLAG_W-1:0] flags_out;
    logic                      satisfied;
    logic [efg_pkg::SLOT_W-1:0] waiter_slot;
    logic [efg_pkg::WAKE_W-1:0] wake_vector;
    modport source (output valid, status, new_handle, flags_out, satisfied, waiter_slot,
                    wake_vector, input ready);
    modport sink (input valid, status, new_handle, flags_out, satisfied, waiter_slot,
                  wake_vector, output ready);
endinterface

// ===== hdl/event_flag_group_engine_unit.sv =====
// Event flag group engine: a table of GROUPS flag groups with WAITERS waiter slots each,
// driven by create/close/free/post/wait/status commands, one result per command.
// A front stage registers and pre-checks each command; the back end takes it in S_IDLE
// (row snapshot), computes and writes the row back in S_EXEC, and presents the result
// in S_OUT until it is taken. Commands are handled one at a time: the back end takes a
// new command only after the result of the last one has been taken, and an output stall
// holds it in S_OUT.
module event_flag_group_engine_unit #(
    parameter int GROUPS  = 16,
    parameter int WAITERS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    efg_in_if.sink    i_in,
    efg_out_if.source o_out
);
    import efg_pkg::*;

    logic q_valid, q_ready;
    t_cmd q_cmd;

    efg_front u_front (
        .i_clk, .i_rst_n, .i_in,
        .o_q_valid(q_valid), .o_q_cmd(q_cmd), .i_q_ready(q_ready)
    );

    efg_back #(.GROUPS(GROUPS), .WAITERS(WAITERS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_cmd(q_cmd), .o_q_ready(q_ready), .o_out
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid) else $error("result dropped");
    a_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.new_handle != '0 |-> o_out.status == ST_OK)
        else $error("handle with error");
    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.wake_vector != '0 |-> o_out.flags_out == '0)
        else $error("wake with flags");
endmodule

// ===== hdl/efg_front.sv =====
module efg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    efg_in_if.sink          i_in,
    output logic            o_q_valid,
    output efg_pkg::t_cmd   o_q_cmd,
    input  logic            i_q_ready
);
    import efg_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;

    // static classification: unknown op, handle zero
    always_comb begin
        n_cmd.op     = i_in.operation;
        n_cmd.handle = i_in.handle;
        n_cmd.mask   = i_in.flag_mask;
        n_cmd.mode   = i_in.merge_mode;
        n_cmd.wid    = i_in.waiter_id;
        priority if (i_in.operation > OP_STATUS) n_cmd.pre_st = ST_BADMODE;
        else if (i_in.operation != OP_CREATE && i_in.handle == '0) n_cmd.pre_st = ST_ZERO;
        else n_cmd.pre_st = ST_OK;
    end

    assign i_in.ready = !r_valid || i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_cmd   = r_cmd;
endmodule

// ===== hdl/efg_back.sv =====
module efg_back #(
    parameter int GROUPS  = 16,
    parameter int WAITERS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  efg_pkg::t_cmd   i_q_cmd,
    output logic            o_q_ready,
    efg_out_if.source       o_out
);
    import efg_pkg::*;

    localparam int GI_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int WI_W = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int GC_W = $clog2(GROUPS + 1);

    logic [GROUPS-1:0]               r_in_use;
    logic [7:0]                      r_open  [GROUPS];
    logic [FLAG_W-1:0]               r_flags [GROUPS];
    logic [GC_W-1:0]                 r_count;
    logic [WAITERS-1:0]              r_wv    [GROUPS];
    logic [WID_W-1:0]                r_wid   [GROUPS][WAITERS];
    logic [FLAG_W-1:0]               r_wreq  [GROUPS][WAITERS];
    logic [WAITERS-1:0]              r_wall  [GROUPS];

    t_state r_state, n_state;
    t_cmd   r_cmd;
    t_res   r_res, n_res;
    logic [GI_W-1:0] r_g;
    logic            r_ok;
    // row snapshot taken when the command is taken in S_IDLE
    logic [FLAG_W-1:0]  r_rf;
    logic [7:0]         r_ro;
    logic [WAITERS-1:0] r_rv, r_ra;
    logic [WID_W-1:0]   r_rid [WAITERS];
    logic [FLAG_W-1:0]  r_rq  [WAITERS];

    logic [GI_W-1:0] hidx;
    logic            hok;
    assign hidx = GI_W'(i_q_cmd.handle - 5'd1);
    assign hok  = (32'(i_q_cmd.handle) <= GROUPS) && r_in_use[hidx];

    assign o_q_ready = (r_state == S_IDLE);

    // lowest free group
    logic [GI_W-1:0] free_g;
    logic            free_hit;
    always_comb begin
        free_g = '0; free_hit = 1'b0;
        for (int j = GROUPS - 1; j >= 0; j--) begin
            if (!r_in_use[j]) begin
                free_g = GI_W'(j); free_hit = 1'b1;
            end
        end
    end

    // S_EXEC compute
    logic [FLAG_W-1:0]  newf, fresh;
    logic [WAITERS-1:0] wake;
    logic [WI_W-1:0]    mslot, fslot;
    logic               mhit, fhit, badm, sat;
    always_comb begin
        newf = r_rf; fresh = '0; badm = 1'b0;
        unique case (r_cmd.mode)
            MODE_AND:  newf = r_rf & r_cmd.mask;
            MODE_OR:   begin newf = r_rf | r_cmd.mask; fresh = r_cmd.mask; end
            MODE_REPL: begin newf = r_cmd.mask; fresh = r_cmd.mask; end
            MODE_XOR:  begin newf = r_rf ^ r_cmd.mask; fresh = r_rf ^ r_cmd.mask; end
            default:   badm = 1'b1;
        endcase
        wake = '0;
        for (int j = 0; j < WAITERS; j++) begin
            if (r_rv[j] && (fresh & r_rq[j]) != '0 &&
                (!r_ra[j] || (newf & r_rq[j]) == r_rq[j]))
                wake[j] = 1'b1;
        end
        mslot = '0; mhit = 1'b0; fslot = '0; fhit = 1'b0;
        for (int j = WAITERS - 1; j >= 0; j--) begin
            if (r_rv[j] && r_rid[j] == r_cmd.wid) begin
                mslot = WI_W'(j); mhit = 1'b1;
            end
            if (!r_rv[j]) begin
                fslot = WI_W'(j); fhit = 1'b1;
            end
        end
        if (r_cmd.mode == WAIT_EVERY) sat = (r_cmd.mask & r_rf) == r_cmd.mask;
        else sat = (r_cmd.mask & r_rf) != '0;
    end

    logic [WI_W-1:0] wslot;
    assign wslot = mhit ? mslot : fslot;

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_EXEC;
            S_EXEC: begin
                n_res = '0;
                n_state = S_OUT;
                if (r_cmd.pre_st != ST_OK) n_res.status = r_cmd.pre_st;
                else if (r_cmd.op == OP_CREATE) begin
                    if (free_hit && 32'(r_count) < GROUPS)
                        n_res.new_handle = HDL_W'(free_g) + 5'd1;
                    else n_res.status = ST_NOROOM;
                end else if (!r_ok) n_res.status = ST_NOGROUP;
                else begin
                    unique case (r_cmd.op)
                        OP_CLOSE: if (r_ro == '0) n_res.status = ST_NOTOPEN;
                        OP_POST: begin
                            if (badm) n_res.status = ST_BADMODE;
                            else n_res.wake_vector = WAKE_W'(wake);
                        end
                        OP_WAIT: begin
                            if (r_cmd.mode > WAIT_ANY) n_res.status = ST_BADMODE;
                            else if (!mhit && !fhit) n_res.status = ST_NOROOM;
                            else begin
                                n_res.flags_out   = r_rf;
                                n_res.satisfied   = sat;
                                n_res.waiter_slot = SLOT_W'(wslot);
                            end
                        end
                        OP_STATUS: n_res.flags_out = r_rf & r_cmd.mask;
                        default: ;
                    endcase
                end
            end
            S_OUT: if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            r_count  <= '0;
            for (int g = 0; g < GROUPS; g++) r_wv[g] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC && r_cmd.pre_st == ST_OK) begin
                if (r_cmd.op == OP_CREATE) begin
                    if (free_hit && 32'(r_count) < GROUPS) begin
                        r_in_use[free_g] <= 1'b1;
                        r_open[free_g]   <= 8'd1;
                        r_flags[free_g]  <= '0;
                        r_count          <= r_count + 1'b1;
                    end
                end else if (r_ok) begin
                    unique case (r_cmd.op)
                        OP_CLOSE: if (r_ro != '0) r_open[r_g] <= r_ro - 8'd1;
                        OP_FREE: begin
                            r_in_use[r_g] <= 1'b0;
                            r_wv[r_g]     <= '0;
                            r_count       <= r_count - 1'b1;
                        end
                        OP_POST: if (!badm) r_flags[r_g] <= newf;
                        OP_WAIT: if (r_cmd.mode <= WAIT_ANY && (mhit || fhit)) begin
                            r_wv[r_g][wslot]   <= 1'b1;
                            r_wid[r_g][wslot]  <= r_cmd.wid;
                            r_wreq[r_g][wslot] <= r_cmd.mask;
                            r_wall[r_g][wslot] <= (r_cmd.mode == WAIT_EVERY);
                        end
                        default: ;
                    endcase
                end
            end
        end
        if (r_state == S_IDLE && i_q_valid) begin
            r_cmd <= i_q_cmd;
            r_g   <= hidx;
            r_ok  <= hok;
            r_rf  <= r_flags[hidx];
            r_ro  <= r_open[hidx];
            r_rv  <= r_wv[hidx];
            r_ra  <= r_wall[hidx];
            for (int j = 0; j < WAITERS; j++) begin
                r_rid[j] <= r_wid[hidx][j];
                r_rq[j]  <= r_wreq[hidx][j];
            end
        end
        r_res <= n_res;
    end

    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.status      = r_res.status;
    assign o_out.new_handle  = r_res.new_handle;
    assign o_out.flags_out   = r_res.flags_out;
    assign o_out.satisfied   = r_res.satisfied;
    assign o_out.waiter_slot = r_res.waiter_slot;
    assign o_out.wake_vector = r_res.wake_vector;
endmodule
